// ===== rtl/core/rfbp_pkg.sv =====
// Shared types, codes and constants of the RFB client stream parser.
package rfbp_pkg;

    // Version string handling
    localparam int unsigned VERSION_LEN = 12;
    localparam int unsigned MINOR_POS   = 10;
    localparam int unsigned HDR_DEPTH   = 12;
    localparam int unsigned HDR_IDX_W   = $clog2(HDR_DEPTH);

    // Event codes carried on the result channel
    localparam logic [3:0] EV_V3      = 4'd0;
    localparam logic [3:0] EV_V7      = 4'd1;
    localparam logic [3:0] EV_INIT    = 4'd2;
    localparam logic [3:0] EV_PIXFMT  = 4'd3;
    localparam logic [3:0] EV_ENCS    = 4'd4;
    localparam logic [3:0] EV_UPDATE  = 4'd5;
    localparam logic [3:0] EV_KEY     = 4'd6;
    localparam logic [3:0] EV_POINTER = 4'd7;
    localparam logic [3:0] EV_CUTTEXT = 4'd8;
    localparam logic [3:0] EV_ERROR   = 4'd9;

    // Client message type bytes
    localparam logic [7:0] MT_PIXFMT  = 8'd0;
    localparam logic [7:0] MT_ENCS    = 8'd2;
    localparam logic [7:0] MT_UPDATE  = 8'd3;
    localparam logic [7:0] MT_KEY     = 8'd4;
    localparam logic [7:0] MT_POINTER = 8'd5;
    localparam logic [7:0] MT_CUTTEXT = 8'd6;

    // Negotiated minor versions
    localparam logic [3:0] MINOR_3 = 4'd3;
    localparam logic [3:0] MINOR_7 = 4'd7;
    localparam logic [3:0] MINOR_8 = 4'd8;
    localparam logic [3:0] MINOR_NONE = 4'd0;

    // Queue between parser front and output back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One parsed event: code, version and message bytes 1..9
    typedef struct packed {
        logic [3:0]      ev;
        logic [3:0]      ver;
        logic [8:0][7:0] body;
    } t_rec;

    // Expected version string byte; the minor digit position is checked apart
    function automatic logic [7:0] ver_char(input logic [HDR_IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h52; // 'R'
            4'd1:    c = 8'h46; // 'F'
            4'd2:    c = 8'h42; // 'B'
            4'd3:    c = 8'h20; // ' '
            4'd4:    c = 8'h30; // '0'
            4'd5:    c = 8'h30;
            4'd6:    c = 8'h33; // '3'
            4'd7:    c = 8'h2e; // '.'
            4'd8:    c = 8'h30;
            4'd9:    c = 8'h30;
            4'd11:   c = 8'h0a; // newline
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Minor digit to negotiated version, none for an unsupported digit
    function automatic logic [3:0] minor_of(input logic [7:0] c);
        logic [3:0] m;
        case (c)
            8'h33:   m = MINOR_3;
            8'h35:   m = MINOR_3;
            8'h37:   m = MINOR_7;
            8'h38:   m = MINOR_8;
            default: m = MINOR_NONE;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/rfbp_ifs.sv =====
// Valid/ready channel interfaces for received bytes and parsed events.
interface rfbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfbp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [3:0]  proto_version;
    logic [7:0]  incremental;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_w;
    logic [15:0] rect_h;
    logic [31:0] keysym;
    logic [7:0]  key_down;

    modport source (output valid, output event_res, output proto_version, output incremental,
                    output rect_x, output rect_y, output rect_w, output rect_h,
                    output keysym, output key_down, input ready);
    modport sink   (input valid, input event_res, input proto_version, input incremental,
                    input rect_x, input rect_y, input rect_w, input rect_h,
                    input keysym, input key_down, output ready);
endinterface

// ===== rtl/core/rfbp_front.sv =====
// Parser front: takes one byte a beat, tracks phase and framing, queues events.
module rfbp_front
    import rfbp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rfbp_in_if.sink      i_rx,
    input  logic         i_q_ready,
    output logic         o_push,
    output t_rec         o_rec
);

    typedef enum logic [1:0] {PH_VERSION, PH_INIT, PH_MAIN, PH_FAILED} t_phase;

    t_phase      r_phase, n_phase;
    logic [32:0] r_count, n_count;
    logic [32:0] r_len,   n_len;
    logic [7:0]  r_kind,  n_kind;
    logic [3:0]  r_neg,   n_neg;
    logic        r_pre,   n_pre;
    logic [7:0]  r_hdr [HDR_DEPTH];

    logic        accept;
    logic [7:0]  b;
    logic [32:0] cnt_inc;
    logic [7:0]  view [1:9];
    logic        pre_ok;
    logic [3:0]  minor;
    logic        first;
    logic [7:0]  cur_kind;
    logic [32:0] cur_len;
    logic [32:0] len_eff;
    logic        known;
    logic        hdr_we;
    logic [3:0]  ev;
    logic [3:0]  ver;

    assign i_rx.ready = i_q_ready;
    assign accept     = i_rx.valid & i_q_ready;
    assign b          = i_rx.rx_byte;
    assign cnt_inc    = r_count + 33'd1;
    assign first      = (r_count == 33'd0);

    // Message bytes as seen at this beat: the current byte overrides its slot
    always_comb begin
        for (int i = 1; i <= 9; i++) begin
            view[i] = (r_count == 33'(i)) ? b : r_hdr[i];
        end
    end

    // Version string checks
    assign pre_ok = r_pre & ((r_count == 33'(MINOR_POS)) ||
                             (b == ver_char(r_count[HDR_IDX_W-1:0])));
    assign minor  = minor_of(r_hdr[MINOR_POS]);

    // Type byte lookup: fixed lengths, zero while the length comes later
    always_comb begin
        known   = 1'b1;
        cur_len = r_len;
        if (first) begin
            case (b)
                MT_PIXFMT:  cur_len = 33'd20;
                MT_ENCS:    cur_len = 33'd0;
                MT_UPDATE:  cur_len = 33'd10;
                MT_KEY:     cur_len = 33'd8;
                MT_POINTER: cur_len = 33'd6;
                MT_CUTTEXT: cur_len = 33'd0;
                default: begin
                    known   = 1'b0;
                    cur_len = 33'd0;
                end
            endcase
        end
    end

    assign cur_kind = first ? b : r_kind;

    // Variable lengths become known at the 4th or 8th byte
    always_comb begin
        len_eff = cur_len;
        if (cur_kind == MT_ENCS && cnt_inc == 33'd4) begin
            len_eff = 33'd4 + {15'd0, view[2], view[3], 2'b00};
        end else if (cur_kind == MT_CUTTEXT && cnt_inc == 33'd8) begin
            len_eff = 33'd8 + {1'b0, view[4], view[5], view[6], view[7]};
        end
    end

    // Next state and event selection
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_len   = r_len;
        n_kind  = r_kind;
        n_neg   = r_neg;
        n_pre   = r_pre;
        hdr_we  = 1'b0;
        o_push  = 1'b0;
        ev      = EV_ERROR;
        ver     = r_neg;
        case (r_phase)
            PH_VERSION: begin
                if (accept) begin
                    hdr_we  = 1'b1;
                    n_pre   = pre_ok;
                    n_count = cnt_inc;
                    if (r_count == 33'(VERSION_LEN - 1)) begin
                        n_count = 33'd0;
                        n_pre   = 1'b1;
                        o_push  = 1'b1;
                        if (pre_ok && minor != MINOR_NONE) begin
                            n_neg   = minor;
                            n_phase = PH_INIT;
                            ev      = (minor >= MINOR_7) ? EV_V7 : EV_V3;
                            ver     = minor;
                        end else begin
                            n_phase = PH_FAILED;
                        end
                    end
                end
            end
            PH_INIT: begin
                if (accept) begin
                    if (r_neg >= MINOR_7 && first) begin
                        n_count = cnt_inc;
                    end else begin
                        n_count = 33'd0;
                        n_phase = PH_MAIN;
                        o_push  = 1'b1;
                        ev      = EV_INIT;
                    end
                end
            end
            PH_MAIN: begin
                if (accept) begin
                    if (!known) begin
                        n_phase = PH_FAILED;
                        o_push  = 1'b1;
                    end else begin
                        hdr_we = (r_count < 33'(HDR_DEPTH));
                        n_kind = cur_kind;
                        if (len_eff != 33'd0 && cnt_inc == len_eff) begin
                            n_count = 33'd0;
                            n_len   = 33'd0;
                            o_push  = 1'b1;
                            case (cur_kind)
                                MT_PIXFMT:  ev = EV_PIXFMT;
                                MT_ENCS:    ev = EV_ENCS;
                                MT_UPDATE:  ev = EV_UPDATE;
                                MT_KEY:     ev = EV_KEY;
                                MT_POINTER: ev = EV_POINTER;
                                default:    ev = EV_CUTTEXT;
                            endcase
                        end else begin
                            n_count = cnt_inc;
                            n_len   = len_eff;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Event record toward the queue
    always_comb begin
        o_rec.ev  = ev;
        o_rec.ver = ver;
        for (int i = 0; i < 9; i++) begin
            o_rec.body[i] = view[i + 1];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VERSION;
            r_count <= '0;
            r_len   <= '0;
            r_kind  <= '0;
            r_neg   <= MINOR_NONE;
            r_pre   <= 1'b1;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_len   <= n_len;
            r_kind  <= n_kind;
            r_neg   <= n_neg;
            r_pre   <= n_pre;
        end
    end

    // Header byte store, first bytes of the current unit
    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_hdr[r_count[HDR_IDX_W-1:0]] <= b;
        end
    end

endmodule

// ===== rtl/core/rfbp_queue.sv =====
// Short event queue between the parser front and the output back.
module rfbp_queue
    import rfbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_rec o_rec
);

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

endmodule

// ===== rtl/core/rfbp_back.sv =====
// Output back: pops events, decodes big-endian fields into the result register.
module rfbp_back
    import rfbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_rec        i_rec,
    output logic        o_pop,
    rfbp_out_if.source  o_ev
);

    logic        r_valid;
    logic [3:0]  r_event, r_ver;
    logic [7:0]  r_incr, r_kdown;
    logic [15:0] r_x, r_y, r_w, r_h;
    logic [31:0] r_ksym;
    logic        is_upd, is_key;

    assign o_pop  = i_q_valid & (~r_valid | o_ev.ready);
    assign is_upd = (i_rec.ev == EV_UPDATE);
    assign is_key = (i_rec.ev == EV_KEY);

    // Beat valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (~r_valid | o_ev.ready) begin
            r_valid <= i_q_valid;
        end
    end

    // Result payload; fields outside their event read as zero
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_event <= i_rec.ev;
            r_ver   <= i_rec.ver;
            r_incr  <= is_upd ? i_rec.body[0] : 8'd0;
            r_x     <= is_upd ? {i_rec.body[1], i_rec.body[2]} : 16'd0;
            r_y     <= is_upd ? {i_rec.body[3], i_rec.body[4]} : 16'd0;
            r_w     <= is_upd ? {i_rec.body[5], i_rec.body[6]} : 16'd0;
            r_h     <= is_upd ? {i_rec.body[7], i_rec.body[8]} : 16'd0;
            r_ksym  <= is_key ? {i_rec.body[3], i_rec.body[4], i_rec.body[5], i_rec.body[6]}
                              : 32'd0;
            r_kdown <= is_key ? i_rec.body[0] : 8'd0;
        end
    end

    assign o_ev.valid         = r_valid;
    assign o_ev.event_res     = r_event;
    assign o_ev.proto_version = r_ver;
    assign o_ev.incremental   = r_incr;
    assign o_ev.rect_x        = r_x;
    assign o_ev.rect_y        = r_y;
    assign o_ev.rect_w        = r_w;
    assign o_ev.rect_h        = r_h;
    assign o_ev.keysym        = r_ksym;
    assign o_ev.key_down      = r_kdown;

endmodule

// ===== rtl/core/rfb_client_message_parser.sv =====
// RFB client stream parser, top level.
// i_rx carries the client byte stream, one byte a beat (valid/ready).
// o_ev carries one event beat per finished unit: version accepted, client
// init done, each framed client message, or an error, with the update
// request and key event fields decoded big-endian.
// Throughput: one byte a cycle while the queue has room; the per-byte framing
// step in the front sets this figure. An event passes from the front into the
// queue, then from the queue into the output register that drives o_ev.
// A two-entry queue and the output register sit between input and output,
// so bytes keep flowing while an event waits; i_rx.ready drops only when
// the queue is full because o_ev.ready has been held low.
// After an error event the block takes and drops every byte until reset.
// Reset (i_rst_n low, synchronous) returns to the version handshake with
// the queue and output empty.
module rfb_client_message_parser
    import rfbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rfbp_in_if.sink    i_rx,
    rfbp_out_if.source o_ev
);

    logic push, q_ready, q_valid, pop;
    t_rec front_rec, q_rec;

    rfbp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_rec     (front_rec)
    );

    rfbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    rfbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_rec     (q_rec),
        .o_pop     (pop),
        .o_ev      (o_ev)
    );

endmodule

// ===== tb/sv/rfb_client_message_parser_test.sv =====
// Self-checking testbench of the RFB client stream parser: byte stream in, parsed events out.
module rfb_client_message_parser_test;
    import rfbp_pkg::*;

    // Parser phases as tracked by the local parse model
    localparam logic [1:0] ST_VERSION  = 2'd0;
    localparam logic [1:0] ST_INIT     = 2'd1;
    localparam logic [1:0] ST_MESSAGES = 2'd2;
    localparam logic [1:0] ST_FAILED   = 2'd3;

    // Body fill styles for generated messages
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    localparam logic [79:0] VER_HEAD      = "RFB 003.00";
    localparam logic [7:0]  NEWLINE       = 8'h0a;
    localparam int          RANDOM_BYTES  = 970;
    localparam int          CYCLE_LIMIT   = 150000;
    localparam int          DRAIN_CYCLES  = 10;
    localparam int          IDLE_PERCENT  = 22;

    typedef struct packed {
        logic [3:0]  ev;
        logic [3:0]  ver;
        logic [7:0]  incr;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [31:0] sym;
        logic [7:0]  down;
    } t_parsed_event;

    // One stimulus byte; pinned rows carry an event code fixed by hand
    typedef struct {
        logic [7:0] data;
        bit         pinned;
        logic [3:0] ev;
        logic [3:0] ver;
    } t_stim_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rfbp_in_if  rx_ch ();
    rfbp_out_if ev_ch ();

    rfb_client_message_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_ev    (ev_ch)
    );

    always #4 i_clk = ~i_clk;

    t_stim_byte    stream[$];
    t_parsed_event pending_events[$];
    int            taken      = 0;
    int            mismatches = 0;
    int            cycles     = 0;
    logic [3:0]    minor_num;

    // Local parse model state
    logic [1:0]  ph   = ST_VERSION;
    logic [3:0]  neg  = MINOR_NONE;
    logic [32:0] cnt  = '0;
    logic [7:0]  kind = '0;
    logic [7:0]  hdr [HDR_DEPTH];
    logic [32:0] mlen = '0;

    initial foreach (hdr[i]) hdr[i] = '0;

    // No idling on either side while this stretch of bytes goes through
    function automatic bit calm_window();
        return taken >= 400 && taken < 700;
    endfunction

    // Advance the parse model by one byte; returns 1 when an event results
    function automatic bit parse_byte(input logic [7:0] b, output t_parsed_event r);
        logic [3:0] m;
        bit         head_ok;
        r = '0;
        case (ph)
            ST_VERSION: begin
                if (cnt < HDR_DEPTH) hdr[cnt[3:0]] = b;
                cnt = cnt + 1;
                if (cnt < VERSION_LEN) return 1'b0;
                cnt = '0;
                head_ok = hdr[11] == NEWLINE;
                for (int i = 0; i < 10; i++)
                    if (hdr[i] != VER_HEAD[79 - 8*i -: 8]) head_ok = 1'b0;
                case (hdr[10])
                    "3", "5": m = MINOR_3;
                    "7":      m = MINOR_7;
                    "8":      m = MINOR_8;
                    default:  m = MINOR_NONE;
                endcase
                if (!head_ok || m == MINOR_NONE) begin
                    ph = ST_FAILED;
                    r.ev = EV_ERROR;
                    r.ver = neg;
                    return 1'b1;
                end
                neg = m;
                ph = ST_INIT;
                r.ev = (m >= MINOR_7) ? EV_V7 : EV_V3;
                r.ver = neg;
                return 1'b1;
            end
            ST_INIT: begin
                cnt = cnt + 1;
                if (cnt < ((neg >= MINOR_7) ? 2 : 1)) return 1'b0;
                cnt = '0;
                ph = ST_MESSAGES;
                r.ev = EV_INIT;
                r.ver = neg;
                return 1'b1;
            end
            ST_MESSAGES: begin
                // type byte opens a message and fixes its length where known
                if (cnt == 0) begin
                    kind = b;
                    case (b)
                        MT_PIXFMT:  mlen = 33'd20;
                        MT_ENCS:    mlen = '0;
                        MT_UPDATE:  mlen = 33'd10;
                        MT_KEY:     mlen = 33'd8;
                        MT_POINTER: mlen = 33'd6;
                        MT_CUTTEXT: mlen = '0;
                        default: begin
                            ph = ST_FAILED;
                            r.ev = EV_ERROR;
                            r.ver = neg;
                            return 1'b1;
                        end
                    endcase
                end
                if (cnt < HDR_DEPTH) hdr[cnt[3:0]] = b;
                cnt = cnt + 1;
                if (kind == MT_ENCS && cnt == 4)
                    mlen = 33'd4 + 33'd4 * 33'({hdr[2], hdr[3]});
                if (kind == MT_CUTTEXT && cnt == 8)
                    mlen = 33'd8 + 33'({hdr[4], hdr[5], hdr[6], hdr[7]});
                if (mlen == 0 || cnt != mlen) return 1'b0;
                cnt = '0;
                mlen = '0;
                r.ver = neg;
                case (kind)
                    MT_PIXFMT:  r.ev = EV_PIXFMT;
                    MT_ENCS:    r.ev = EV_ENCS;
                    MT_UPDATE: begin
                        r.ev   = EV_UPDATE;
                        r.incr = hdr[1];
                        r.x    = {hdr[2], hdr[3]};
                        r.y    = {hdr[4], hdr[5]};
                        r.w    = {hdr[6], hdr[7]};
                        r.h    = {hdr[8], hdr[9]};
                    end
                    MT_KEY: begin
                        r.ev   = EV_KEY;
                        r.sym  = {hdr[4], hdr[5], hdr[6], hdr[7]};
                        r.down = hdr[1];
                    end
                    MT_POINTER: r.ev = EV_POINTER;
                    default:    r.ev = EV_CUTTEXT;
                endcase
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void put(input logic [7:0] data, input bit pinned, input logic [3:0] ev);
        t_stim_byte s;
        s.data   = data;
        s.pinned = pinned;
        s.ev     = ev;
        s.ver    = minor_num;
        stream.push_back(s);
    endfunction

    function automatic logic [7:0] fill_byte(input int fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hff;
            default:   return 8'($urandom_range(255));
        endcase
    endfunction

    // Queue one client message; size is the encoding count or the cut-text length
    function automatic void put_message(input logic [7:0] mtype, input int unsigned size,
                                        input int fill, input bit pinned);
        logic [7:0]  body[$];
        logic [3:0]  done_ev;
        int unsigned extra;
        body.push_back(mtype);
        case (mtype)
            MT_PIXFMT:  begin done_ev = EV_PIXFMT;  extra = 19; end
            MT_UPDATE:  begin done_ev = EV_UPDATE;  extra = 9;  end
            MT_KEY:     begin done_ev = EV_KEY;     extra = 7;  end
            MT_POINTER: begin done_ev = EV_POINTER; extra = 5;  end
            MT_ENCS: begin
                done_ev = EV_ENCS;
                body.push_back(fill_byte(fill));
                body.push_back(size[15:8]);
                body.push_back(size[7:0]);
                extra = 4 * size[15:0];
            end
            default: begin
                done_ev = EV_CUTTEXT;
                repeat (3) body.push_back(fill_byte(fill));
                body.push_back(size[31:24]);
                body.push_back(size[23:16]);
                body.push_back(size[15:8]);
                body.push_back(size[7:0]);
                extra = size;
            end
        endcase
        repeat (extra) body.push_back(fill_byte(fill));
        foreach (body[i]) put(body[i], pinned && i == body.size() - 1, done_ev);
    endfunction

    // Receive side: random stalls outside the calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ev_ch.ready <= 1'b0;
        end else begin
            ev_ch.ready <= calm_window() || $urandom_range(99) >= IDLE_PERCENT;
        end
    end

    // Track accepted bytes into the model, compare every event beat
    always @(posedge i_clk) begin : watch
        t_parsed_event want;
        t_parsed_event got;
        bit            hit;
        if (i_rst_n) begin
            if (rx_ch.valid && rx_ch.ready) begin
                hit = parse_byte(rx_ch.rx_byte, want);
                if (stream[taken].pinned) begin
                    want     = '0;
                    want.ev  = stream[taken].ev;
                    want.ver = stream[taken].ver;
                    hit      = 1'b1;
                end
                if (hit) pending_events.push_back(want);
                taken <= taken + 1;
            end
            if (ev_ch.valid && ev_ch.ready) begin
                got.ev   = ev_ch.event_res;
                got.ver  = ev_ch.proto_version;
                got.incr = ev_ch.incremental;
                got.x    = ev_ch.rect_x;
                got.y    = ev_ch.rect_y;
                got.w    = ev_ch.rect_w;
                got.h    = ev_ch.rect_h;
                got.sym  = ev_ch.keysym;
                got.down = ev_ch.key_down;
                if (pending_events.size() == 0) begin
                    $error("event beat with nothing expected: event_res %0d", got.ev);
                    mismatches++;
                end else begin
                    want = pending_events.pop_front();
                    if (got !== want) mismatches++;
                    if (got.ev !== want.ev)
                        $error("event_res: expected %0d, got %0d", want.ev, got.ev);
                    if (got.ver !== want.ver)
                        $error("proto_version: expected %0d, got %0d", want.ver, got.ver);
                    if (got.incr !== want.incr)
                        $error("incremental: expected %0h, got %0h", want.incr, got.incr);
                    if (got.x !== want.x)
                        $error("rect_x: expected %0h, got %0h", want.x, got.x);
                    if (got.y !== want.y)
                        $error("rect_y: expected %0h, got %0h", want.y, got.y);
                    if (got.w !== want.w)
                        $error("rect_w: expected %0h, got %0h", want.w, got.w);
                    if (got.h !== want.h)
                        $error("rect_h: expected %0h, got %0h", want.h, got.h);
                    if (got.sym !== want.sym)
                        $error("keysym: expected %0h, got %0h", want.sym, got.sym);
                    if (got.down !== want.down)
                        $error("key_down: expected %0h, got %0h", want.down, got.down);
                end
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("rfb_client_message_parser regression: fail");
            $finish;
        end
    end

    initial begin : drive
        logic [7:0]  minor_ch;
        logic [7:0]  mtype;
        int unsigned size;
        int          fill;
        int          pick;
        int          first_random;

        i_rst_n       = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;

        // version handshake with a random supported minor digit
        case ($urandom_range(3))
            0:       begin minor_ch = "3"; minor_num = MINOR_3; end
            1:       begin minor_ch = "5"; minor_num = MINOR_3; end
            2:       begin minor_ch = "7"; minor_num = MINOR_7; end
            default: begin minor_ch = "8"; minor_num = MINOR_8; end
        endcase
        for (int i = 0; i < 10; i++) put(VER_HEAD[79 - 8*i -: 8], 1'b0, EV_V3);
        put(minor_ch, 1'b0, EV_V3);
        put(NEWLINE, 1'b1, (minor_num >= MINOR_7) ? EV_V7 : EV_V3);

        // client init: two bytes from 3.7 on, else one
        if (minor_num >= MINOR_7) put(8'hff, 1'b0, EV_INIT);
        put(8'h00, 1'b1, EV_INIT);

        // directed messages: every type, field extremes, empty and long bodies
        put_message(MT_PIXFMT,  0,  FILL_ONES,   1'b1);
        put_message(MT_ENCS,    0,  FILL_RANDOM, 1'b1);
        put_message(MT_UPDATE,  0,  FILL_ONES,   1'b0);
        put_message(MT_UPDATE,  0,  FILL_ZERO,   1'b0);
        put_message(MT_KEY,     0,  FILL_ONES,   1'b0);
        put_message(MT_KEY,     0,  FILL_ZERO,   1'b0);
        put_message(MT_POINTER, 0,  FILL_RANDOM, 1'b1);
        put_message(MT_ENCS,    1,  FILL_ONES,   1'b1);
        put_message(MT_CUTTEXT, 0,  FILL_RANDOM, 1'b1);
        put_message(MT_CUTTEXT, 20, FILL_RANDOM, 1'b1);

        // random well-formed messages, mostly short, a few with long bodies
        first_random = stream.size();
        while (stream.size() < first_random + RANDOM_BYTES) begin
            case ($urandom_range(5))
                0:       mtype = MT_PIXFMT;
                1:       mtype = MT_ENCS;
                2:       mtype = MT_UPDATE;
                3:       mtype = MT_KEY;
                4:       mtype = MT_POINTER;
                default: mtype = MT_CUTTEXT;
            endcase
            pick = $urandom_range(99);
            size = 0;
            if (mtype == MT_ENCS)
                size = (pick < 90) ? $urandom_range(4) :
                       (pick < 99) ? $urandom_range(40, 5) : $urandom_range(300, 256);
            else if (mtype == MT_CUTTEXT)
                size = (pick < 85) ? $urandom_range(12) :
                       (pick < 99) ? $urandom_range(200, 13) : $urandom_range(1023, 256);
            pick = $urandom_range(19);
            fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RANDOM;
            put_message(mtype, size, fill, 1'b0);
        end

        // unknown type byte ends parsing; later bytes are dropped silently
        pick = $urandom_range(250, 1);
        put((pick == 1) ? 8'd1 : 8'(pick + 5), 1'b1, EV_ERROR);
        repeat (8) put(8'($urandom_range(255)), 1'b0, EV_ERROR);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // byte source with random gaps
        foreach (stream[i]) begin
            while (!calm_window() && $urandom_range(99) < IDLE_PERCENT) begin
                rx_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            rx_ch.valid   <= 1'b1;
            rx_ch.rx_byte <= stream[i].data;
            @(posedge i_clk);
            while (!rx_ch.ready) @(posedge i_clk);
        end
        rx_ch.valid <= 1'b0;

        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("rfb_client_message_parser regression: pass");
        end else begin
            $display("rfb_client_message_parser regression: fail");
        end
        $finish;
    end

endmodule
